/* sv/hcfb_pkg.sv */
// ----------------------------------------------------------------------------
// hcfb_pkg
// Types and constants shared by the header/checksum frame builder.
// ----------------------------------------------------------------------------
package hcfb_pkg;

	localparam logic [7:0] SYNC_FIRST   = 8'hAA;
	localparam logic [7:0] SYNC_SECOND  = 8'h55;
	localparam logic [7:0] LENGTH_RESET = 8'd76;
	localparam logic [7:0] PAD_BYTE     = 8'h00;

	// configuration register indexes
	typedef enum logic [0:0] {
		REG_NODE_ADDRESS = 1'b0,
		REG_LENGTH_BYTE  = 1'b1
	} reg_index_t;

	// position of the next byte within the bytes caused by one input word
	typedef enum logic [3:0] {
		POS_SYNC1  = 4'd0,
		POS_SYNC2  = 4'd1,
		POS_LENGTH = 4'd2,
		POS_SEQ    = 4'd3,
		POS_NODE   = 4'd4,
		POS_MTYPE  = 4'd5,
		POS_LINK   = 4'd6,
		POS_ACK    = 4'd7,
		POS_DATA   = 4'd8,
		POS_PAD    = 4'd9,
		POS_SUM    = 4'd10
	} pos_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_byte;
		logic       last_byte;
		logic [7:0] sequence_number;
		logic [7:0] msg_kind;
		logic [7:0] link_method;
		logic       ack_request;
	} in_word_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       frame_end;
	} out_word_t;

	typedef struct packed {
		logic [7:0] node_address;
		logic [7:0] length_byte;
	} cfg_t;

endpackage

/* sv/header_checksum_frame_builder.sv */
// ----------------------------------------------------------------------------
// header_checksum_frame_builder
// Wraps a payload byte stream in link frames: sync/header ahead of the first
// byte, zero pad and 8-bit additive checksum after the last byte.
// ----------------------------------------------------------------------------
//
//  channel   | signals                         | word
//  ----------+---------------------------------+---------------------------
//  input     | in_valid / in_ready / in_data   | one payload byte + flags
//  output    | out_valid / out_ready / out_data| one framed byte + frame_end
//  config    | cfg_we / cfg_index / cfg_wdata  | node address, length byte
//
// One output byte leaves per cycle while out_ready allows. An input word yields
// 1, 3, 9 or 11 output bytes; plain payload bytes stream at one per cycle when
// the output is not stalled. The held-word register frees on the cycle its
// final byte moves to the output register, so the next input word is taken
// in that same cycle. Reset clears both valids, the running sum and loads the
// register defaults. A stall on out_ready freezes the sequencer.
//
module header_checksum_frame_builder
	import hcfb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  in_word_t   in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output out_word_t  out_data,
	input  logic       cfg_we,
	input  logic [0:0] cfg_index,
	input  logic [7:0] cfg_wdata
);

	// configuration registers
	cfg_t       cfg_q;

	// held input word and its byte position
	logic       valid_s1;
	in_word_t   item_s1;
	pos_t       pos_s1;

	// running frame sum
	logic [7:0] sum_q;

	// output register
	logic       out_valid_q;
	out_word_t  out_q;

	logic       step;
	logic       last_step;
	logic       take;
	out_word_t  sel_word;
	logic [7:0] sum_base;

	// config writes; the user must write only while the block is idle, the block itself does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.node_address <= 8'd0;
			cfg_q.length_byte  <= LENGTH_RESET;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_NODE_ADDRESS: cfg_q.node_address <= cfg_wdata;
				REG_LENGTH_BYTE:  cfg_q.length_byte  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// a byte moves on whenever the output register is empty or being drained
	assign step      = valid_s1 && (!out_valid_q || out_ready);
	// final byte of this word: data byte on a non-last word, else the checksum
	assign last_step = step && ((pos_s1 == POS_SUM) ||
	                            ((pos_s1 == POS_DATA) && !item_s1.last_byte));
	assign in_ready  = !valid_s1 || last_step;
	assign take      = in_valid && in_ready;

	hcfb_byte_sel u_sel (
		.pos         (pos_s1),
		.item        (item_s1),
		.cfg         (cfg_q),
		.running_sum (sum_q),
		.word        (sel_word)
	);

	// the first sync byte opens a new frame, dropping any open sum
	assign sum_base = (pos_s1 == POS_SYNC1) ? 8'd0 : sum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			pos_s1   <= POS_DATA;
		end else if (take) begin
			valid_s1 <= 1'b1;
			pos_s1   <= in_data.first_byte ? POS_SYNC1 : POS_DATA;
		end else if (last_step) begin
			valid_s1 <= 1'b0;
		end else if (step) begin
			pos_s1   <= pos_t'(pos_s1 + 4'd1);
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= in_data;
		end
	end

	// checksum byte clears the sum; everything else adds in
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= 8'd0;
		end else if (step) begin
			if (sel_word.frame_end) begin
				sum_q <= 8'd0;
			end else begin
				sum_q <= sum_base + sel_word.out_byte;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_q <= sel_word;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

/* sv/hcfb_byte_sel.sv */
// ----------------------------------------------------------------------------
// hcfb_byte_sel
// Picks the frame byte for the current position of the held input word.
// ----------------------------------------------------------------------------
module hcfb_byte_sel
	import hcfb_pkg::*;
(
	input  pos_t       pos,
	input  in_word_t   item,
	input  cfg_t       cfg,
	input  logic [7:0] running_sum,
	output out_word_t  word
);

	always_comb begin
		word.frame_end = 1'b0;
		unique case (pos)
			POS_SYNC1:  word.out_byte = SYNC_FIRST;
			POS_SYNC2:  word.out_byte = SYNC_SECOND;
			POS_LENGTH: word.out_byte = cfg.length_byte;
			POS_SEQ:    word.out_byte = item.sequence_number;
			POS_NODE:   word.out_byte = cfg.node_address;
			POS_MTYPE:  word.out_byte = item.msg_kind;
			POS_LINK:   word.out_byte = item.link_method;
			POS_ACK:    word.out_byte = {7'd0, item.ack_request};
			POS_DATA:   word.out_byte = item.data_byte;
			POS_PAD:    word.out_byte = PAD_BYTE;
			POS_SUM: begin
				word.out_byte  = running_sum;
				word.frame_end = 1'b1;
			end
			default:    word.out_byte = PAD_BYTE;
		endcase
	end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for header_checksum_frame_builder. A short table of
// directed words covers the reset state, field extremes, one-byte frames,
// a restart in mid-frame and bytes outside any frame. Random frames follow
// under several register settings. The sender runs in bursts and the
// receiver stalls. Every framed byte is compared with the local predictor.
// ----------------------------------------------------------------------------
module tb_top;
	import hcfb_pkg::*;

	localparam int RAND_PHASES    = 4;
	localparam int WORDS_PER_PHASE = 100;
	localparam int DIR_RESET_ROWS = 4;    // rows run with the reset register values

	// receiver stall patterns
	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_COIN,
		STALL_THIRD,
		STALL_RARE
	} stall_mode_t;

	// one row of the directed table; tail, where typed, replaces the last
	// predicted byte of the row
	typedef struct {
		in_word_t  w;
		bit        typed;
		out_word_t tail;
	} dir_row_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	in_word_t   in_data;
	logic       out_valid;
	logic       out_ready = 1'b0;
	out_word_t  out_data;
	logic       cfg_we;
	logic [0:0] cfg_index;
	logic [7:0] cfg_wdata;

	// predictor state: running sum and its own copy of the registers
	logic [7:0] model_sum;
	logic [7:0] model_node;
	logic [7:0] model_len;

	out_word_t   framed_q[$];   // framed bytes still to come, oldest first
	dir_row_t    dir_rows[$];
	int          mismatches = 0;
	int          burst_left = 0;
	bit          gaps_on = 1'b0;
	stall_mode_t stall_mode;
	logic [5:0]  stall_ctr;

	header_checksum_frame_builder u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// hard stop: far above the slowest legal run (~500 words x 11 bytes,
	// each byte stalled, plus sender gaps)
	initial begin
		#5ms;
		$display("== FAIL ==");
		$finish;
	end

	task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
		$display("%0t ns: %s got %h want %h", $time, what, got, want);
		mismatches++;
	endtask

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------
	function automatic void push_byte(logic [7:0] b, logic closing);
		out_word_t o;
		o.out_byte  = b;
		o.frame_end = closing;
		framed_q.push_back(o);
		// the checksum itself never enters the sum
		if (!closing)
			model_sum = model_sum + b;
	endfunction

	// expected bytes for one accepted word, in order
	function automatic void frame_predict(in_word_t w);
		if (w.first_byte) begin
			// a new header drops whatever sum an open frame had
			model_sum = 8'd0;
			push_byte(SYNC_FIRST, 1'b0);
			push_byte(SYNC_SECOND, 1'b0);
			push_byte(model_len, 1'b0);
			push_byte(w.sequence_number, 1'b0);
			push_byte(model_node, 1'b0);
			push_byte(w.msg_kind, 1'b0);
			push_byte(w.link_method, 1'b0);
			push_byte({7'd0, w.ack_request}, 1'b0);
		end
		push_byte(w.data_byte, 1'b0);
		if (w.last_byte) begin
			push_byte(PAD_BYTE, 1'b0);
			push_byte(model_sum, 1'b1);
			model_sum = 8'd0;
		end
	endfunction

	// ------------------------------------------------------------------------
	// Output side: stall pattern and checking
	// ------------------------------------------------------------------------
	// pattern is redrawn each time stall_ctr wraps; STALL_NONE gives long clean stretches
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready  <= 1'b0;
			stall_ctr  <= '0;
			stall_mode <= STALL_NONE;
		end else begin
			stall_ctr <= stall_ctr + 6'd1;
			if (stall_ctr == '0)
				stall_mode <= stall_mode_t'($urandom_range(0, 3));
			case (stall_mode)
				STALL_NONE:  out_ready <= 1'b1;
				STALL_COIN:  out_ready <= 1'($urandom_range(0, 1));
				STALL_THIRD: out_ready <= (stall_ctr % 3 == 0);
				default:     out_ready <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	always @(posedge clk) begin : check_out
		out_word_t want;
		if (arst_n && out_valid && out_ready) begin
			if (framed_q.size() == 0) begin
				report_mismatch("unexpected word", out_data.out_byte, 8'h00);
			end else begin
				want = framed_q.pop_front();
				if (out_data.out_byte !== want.out_byte)
					report_mismatch("out_byte", out_data.out_byte, want.out_byte);
				if (out_data.frame_end !== want.frame_end)
					report_mismatch("frame_end", {7'd0, out_data.frame_end},
						{7'd0, want.frame_end});
			end
		end
	end

	// ------------------------------------------------------------------------
	// Input side
	// ------------------------------------------------------------------------
	function automatic in_word_t mk_word(logic [7:0] data, logic first, logic last,
		logic [7:0] seq, logic [7:0] mtype, logic [7:0] link, logic ack);
		in_word_t w;
		w.data_byte       = data;
		w.first_byte      = first;
		w.last_byte       = last;
		w.sequence_number = seq;
		w.msg_kind        = mtype;
		w.link_method     = link;
		w.ack_request     = ack;
		return w;
	endfunction

	function automatic in_word_t rand_word(logic first, logic last);
		return mk_word(8'($urandom_range(0, 255)), first, last,
			8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
	endfunction

	task automatic add_row(in_word_t w, bit typed, logic [7:0] b, logic closing);
		dir_row_t r;
		r.w              = w;
		r.typed          = typed;
		r.tail.out_byte  = b;
		r.tail.frame_end = closing;
		dir_rows.push_back(r);
	endtask

	// valid stays high across a burst; a gap only opens between bursts
	task automatic send_word(in_word_t w);
		int gap;
		if (gaps_on && burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		in_valid <= 1'b1;
		in_data  <= w;
		do @(posedge clk); while (!in_ready);
		frame_predict(w);
		if (burst_left != 0)
			burst_left--;
	endtask

	// registers only change with the block drained
	task automatic drain();
		in_valid <= 1'b0;
		while (framed_q.size() != 0) @(posedge clk);
	endtask

	task automatic set_cfg(logic [7:0] node, logic [7:0] len);
		cfg_we    <= 1'b1;
		cfg_index <= REG_NODE_ADDRESS;
		cfg_wdata <= node;
		@(posedge clk);
		model_node = node;
		cfg_index <= REG_LENGTH_BYTE;
		cfg_wdata <= len;
		@(posedge clk);
		model_len = len;
		cfg_we <= 1'b0;
	endtask

	// mostly well-formed frames with random content, some stray words
	task automatic random_phase(int n_words);
		int sent;
		int flen;
		sent = 0;
		while (sent < n_words) begin
			if ($urandom_range(0, 99) < 85) begin
				flen = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24)
					: $urandom_range(1, 6);
				for (int i = 0; i < flen; i++)
					send_word(rand_word(i == 0, i == flen - 1));
				sent += flen;
			end else begin
				send_word(rand_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
				sent++;
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		in_data    = '0;
		cfg_we     = 1'b0;
		cfg_index  = REG_NODE_ADDRESS;
		cfg_wdata  = 8'h00;
		model_sum  = 8'd0;
		model_node = 8'd0;
		model_len  = LENGTH_RESET;

		// reset registers: node 0, length 76
		// stray byte after reset passes straight through
		add_row(mk_word(8'h00, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0), 1'b1, 8'h00, 1'b0);
		// closing without a header: sum is just the byte and the pad
		add_row(mk_word(8'h10, 1'b0, 1'b1, 8'h00, 8'h00, 8'h00, 1'b0), 1'b1, 8'h10, 1'b1);
		// one-byte frame, all fields low: AA+55+4C
		add_row(mk_word(8'h00, 1'b1, 1'b1, 8'h00, 8'h00, 8'h00, 1'b0), 1'b1, 8'h4B, 1'b1);
		// one-byte frame, all fields high
		add_row(mk_word(8'hFF, 1'b1, 1'b1, 8'hFF, 8'hFF, 8'hFF, 1'b1), 1'b1, 8'h48, 1'b1);
		// node FF, length 00 from here on
		add_row(mk_word(8'h01, 1'b1, 1'b0, 8'h01, 8'h80, 8'h7F, 1'b0), 1'b0, 8'h00, 1'b0);
		add_row(mk_word(8'h80, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0), 1'b0, 8'h00, 1'b0);
		add_row(mk_word(8'h7F, 1'b0, 1'b0, 8'hFF, 8'hFF, 8'hFF, 1'b1), 1'b0, 8'h00, 1'b0);
		// restart while the frame is still open
		add_row(mk_word(8'hAA, 1'b1, 1'b0, 8'h02, 8'h7F, 8'h80, 1'b1), 1'b0, 8'h00, 1'b0);
		add_row(mk_word(8'h55, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0), 1'b0, 8'h00, 1'b0);
		add_row(mk_word(8'hFE, 1'b0, 1'b1, 8'h00, 8'h00, 8'h00, 1'b0), 1'b0, 8'h00, 1'b0);
		// bytes between frames
		add_row(mk_word(8'h33, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0), 1'b0, 8'h00, 1'b0);
		add_row(mk_word(8'h44, 1'b0, 1'b1, 8'h00, 8'h00, 8'h00, 1'b0), 1'b0, 8'h00, 1'b0);
		// one-byte frame with the new registers: AA+55+00+FF+FF+00+FF+01
		add_row(mk_word(8'h00, 1'b1, 1'b1, 8'hFF, 8'h00, 8'hFF, 1'b1), 1'b1, 8'hFD, 1'b1);
		add_row(mk_word(8'hFF, 1'b1, 1'b0, 8'h00, 8'hFF, 8'h00, 1'b0), 1'b0, 8'h00, 1'b0);
		add_row(mk_word(8'hFF, 1'b0, 1'b1, 8'hFF, 8'hFF, 8'hFF, 1'b1), 1'b0, 8'h00, 1'b0);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, back to back
		for (int i = 0; i < dir_rows.size(); i++) begin
			if (i == DIR_RESET_ROWS) begin
				drain();
				set_cfg(8'hFF, 8'h00);
			end
			send_word(dir_rows[i].w);
			if (dir_rows[i].typed)
				framed_q[framed_q.size() - 1] = dir_rows[i].tail;
		end

		// random frames under a new register setting each phase; the first
		// phase keeps the sender busy, the rest open gaps between bursts
		for (int p = 0; p < RAND_PHASES; p++) begin
			drain();
			case (p)
				0:       set_cfg(8'h00, 8'hFF);
				1:       set_cfg(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
				2:       set_cfg(8'h00, LENGTH_RESET);
				default: set_cfg(8'hFF, 8'($urandom_range(0, 255)));
			endcase
			gaps_on    = (p != 0);
			burst_left = 0;
			random_phase(WORDS_PER_PHASE);
		end

		drain();
		repeat (16) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
